// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, masked while rst_n is low.
`define HJS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked on clk, checked in reset as well.
`define HJS_ASSERT_RAW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/core/hjs_pkg.sv =====
package hjs_pkg;

  localparam int ACC_FRAC = 48;           // fractional bits of the radical inverse
  localparam int HX_W     = ACC_FRAC + 2; // Horner dividend: base-3 digit over acc
  localparam int JIT_W    = 16;
  localparam int LEFT_W   = 8;
  localparam int ACT_W    = 2;

  localparam logic [LEFT_W-1:0] SETTLE_RST = 8'd16;
  localparam logic [2:0]        BASE3      = 3'd3;

  typedef enum logic [ACT_W-1:0] {
    ACT_PREPARE = 2'd0,
    ACT_FRAME   = 2'd1,
    ACT_CANCEL  = 2'd2
  } hjs_action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } hjs_state_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_DIG,
    E_HORN,
    E_DONE
  } hjs_eng_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hjs_eng_stat_t;

endpackage

// ===== rtl/core/hjs_in_if.sv =====
interface hjs_in_if;
  import hjs_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic             enable;
  logic             restart;
  logic             settle_ok;

  modport source (output valid, output action, output enable, output restart,
                  output settle_ok, input ready);
  modport sink   (input valid, input action, input enable, input restart,
                  input settle_ok, output ready);
endinterface

// ===== rtl/core/hjs_out_if.sv =====
interface hjs_out_if;
  import hjs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [JIT_W-1:0] jitter_x;
  logic signed [JIT_W-1:0] jitter_y;
  logic                    more_frames;
  logic [LEFT_W-1:0]       frames_left;

  modport source (output valid, output jitter_x, output jitter_y, output more_frames,
                  output frames_left, input ready);
  modport sink   (input valid, input jitter_x, input jitter_y, input more_frames,
                  input frames_left, output ready);
endinterface

// ===== rtl/core/hjs_cfg.sv =====
module hjs_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [hjs_pkg::LEFT_W-1:0] settle_frames_o
);
  import hjs_pkg::*;

  // word index bit of the byte address
  localparam logic REG_SETTLE = 1'b0;

  logic              wr_en;
  logic [LEFT_W-1:0] settle_frames_r;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_frames_r <= SETTLE_RST;
    end else if (wr_en && paddr[2] == REG_SETTLE) begin
      settle_frames_r <= pwdata[LEFT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SETTLE) begin
      prdata = {{(32-LEFT_W){1'b0}}, settle_frames_r};
    end
  end

  assign settle_frames_o = settle_frames_r;
endmodule

// ===== rtl/core/hjs_div3.sv =====
// Bit-serial long division by three, dividend MSB first.
module hjs_div3 (
  input  logic       clk,
  input  logic       en_i,
  input  logic       first_i,
  input  logic       bit_i,
  output logic       q_o,
  output logic [1:0] rem_o
);
  import hjs_pkg::*;

  logic [1:0] rem_r;
  logic [1:0] rem_eff;
  logic [2:0] part;

  always_comb begin
    rem_eff = first_i ? 2'd0 : rem_r;
    part    = {rem_eff, bit_i};
    q_o     = (part >= BASE3);
    rem_o   = q_o ? 2'(part - BASE3) : part[1:0];
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      rem_r <= rem_o;
    end
  end
endmodule

// ===== rtl/core/hjs_halton.sv =====
`include "assert_macros.svh"

// Base-2 and base-3 radical inverse of one sample, one bit per cycle.
// Pass 1: ND division passes over the sample peel off base-3 digits onto a stack;
// the first pass also bit-reverses the sample into the base-2 accumulator.
// Pass 2: Horner over the stacked digits, MS digit first, one divide-by-3 per digit.
module hjs_halton #(
  parameter int SMP_W     = 33,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start_i,
  input  logic [SMP_W-1:0]                  sample_i,
  output hjs_pkg::hjs_eng_stat_t            stat_o,
  output logic signed [hjs_pkg::JIT_W-1:0]  jit_x_o,
  output logic signed [hjs_pkg::JIT_W-1:0]  jit_y_o
);
  import hjs_pkg::*;

  // base-3 digits needed to cover 2^SMP_W (log3(2) rounded up)
  localparam int ND      = (SMP_W * 631) / 1000 + 1;
  localparam int CNT_MAX = (SMP_W > HX_W) ? SMP_W : HX_W;
  localparam int BC_W    = $clog2(CNT_MAX);
  localparam int DC_W    = $clog2(ND);
  localparam int SH      = ACC_FRAC - FRAC_BITS;
  localparam int JW      = (FRAC_BITS + 2 > JIT_W + 1) ? FRAC_BITS + 2 : JIT_W + 1;
  localparam logic signed [JW-1:0] JMAX = JW'(32767);
  localparam logic signed [JW-1:0] JMIN = JW'(-32768);
  localparam logic signed [JW-1:0] HALF = JW'(1 << (FRAC_BITS - 1));

  hjs_eng_state_t e_st_r, e_st_nxt;
  logic [BC_W-1:0] bit_cnt_r;
  logic [DC_W-1:0] dig_cnt_r;

  logic [SMP_W-1:0]    smp_r;
  logic [ACC_FRAC-1:0] a2_r;
  logic [HX_W-1:0]     hx_r;
  logic [2*ND-1:0]     stk_r;

  logic            dig_step, horn_step, last_bit, last_dig, div_first, div_bit;
  logic            div_q;
  logic [1:0]      div_rem;
  logic [HX_W-1:0] hx_eff;

  function automatic logic signed [JIT_W-1:0] jit_of(input logic [ACC_FRAC-1:0] acc);
    logic [FRAC_BITS:0]     rnd;
    logic signed [JW-1:0]   jj;
    logic signed [JIT_W-1:0] res;
    // round half up to FRAC_BITS, center on zero, then saturate to JIT_W
    rnd = {1'b0, acc[ACC_FRAC-1:SH]} + (FRAC_BITS+1)'(acc[SH-1]);
    jj  = $signed(JW'(rnd)) - HALF;
    if (jj > JMAX) begin
      res = JMAX[JIT_W-1:0];
    end else if (jj < JMIN) begin
      res = JMIN[JIT_W-1:0];
    end else begin
      res = jj[JIT_W-1:0];
    end
    return res;
  endfunction

  // next state
  always_comb begin
    e_st_nxt = e_st_r;
    case (e_st_r)
      E_IDLE: if (start_i) e_st_nxt = E_DIG;
      E_DIG:  if (last_bit && last_dig) e_st_nxt = E_HORN;
      E_HORN: if (last_bit && last_dig) e_st_nxt = E_DONE;
      E_DONE: e_st_nxt = E_IDLE;
      default: e_st_nxt = E_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    dig_step    = 1'b0;
    horn_step   = 1'b0;
    last_bit    = 1'b0;
    stat_o.busy = (e_st_r != E_IDLE);
    stat_o.done = 1'b0;
    case (e_st_r)
      E_DIG: begin
        dig_step = 1'b1;
        last_bit = (bit_cnt_r == BC_W'(SMP_W - 1));
      end
      E_HORN: begin
        horn_step = 1'b1;
        last_bit  = (bit_cnt_r == BC_W'(HX_W - 1));
      end
      E_DONE: stat_o.done = 1'b1;
      default: ;
    endcase
    last_dig  = (dig_cnt_r == DC_W'(ND - 1));
    div_first = (bit_cnt_r == '0);
    // the next digit drops into the two free top bits of the accumulator
    hx_eff    = div_first ? {stk_r[1:0], hx_r[ACC_FRAC-1:0]} : hx_r;
    div_bit   = horn_step ? hx_eff[HX_W-1] : smp_r[SMP_W-1];
  end

  hjs_div3 u_div3 (
    .clk     (clk),
    .en_i    (dig_step | horn_step),
    .first_i (div_first),
    .bit_i   (div_bit),
    .q_o     (div_q),
    .rem_o   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_st_r    <= E_IDLE;
      bit_cnt_r <= '0;
      dig_cnt_r <= '0;
    end else begin
      e_st_r <= e_st_nxt;
      if (e_st_r == E_IDLE) begin
        bit_cnt_r <= '0;
        dig_cnt_r <= '0;
      end else if (dig_step || horn_step) begin
        if (last_bit) begin
          bit_cnt_r <= '0;
          dig_cnt_r <= last_dig ? '0 : dig_cnt_r + DC_W'(1);
        end else begin
          bit_cnt_r <= bit_cnt_r + BC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_st_r == E_IDLE && start_i) begin
      smp_r <= sample_i;
      a2_r  <= '0;
      hx_r  <= '0;
    end else if (dig_step) begin
      smp_r <= {smp_r[SMP_W-2:0], div_q};
      if (dig_cnt_r == '0) begin
        a2_r <= {smp_r[SMP_W-1], a2_r[ACC_FRAC-1:1]};
      end
      if (last_bit) begin
        stk_r <= {stk_r[2*ND-3:0], div_rem};
      end
    end else if (horn_step) begin
      hx_r <= {hx_eff[HX_W-2:0], div_q};
      if (div_first) begin
        stk_r <= {2'b00, stk_r[2*ND-1:2]};
      end
    end
  end

  assign jit_x_o = jit_of(a2_r);
  assign jit_y_o = jit_of(hx_r[ACC_FRAC-1:0]);

  `HJS_ASSERT(a_hx_room, (e_st_r == E_HORN && bit_cnt_r == '0) |-> (hx_r[HX_W-1 -: 2] == 2'b00), "horner accumulator overflow")
  `HJS_ASSERT(a_done_pulse, stat_o.done |=> !stat_o.done, "done held longer than one cycle")
  `HJS_ASSERT(a_dig_range, (e_st_r == E_DIG || e_st_r == E_HORN) |-> (dig_cnt_r <= DC_W'(ND - 1)), "digit count out of range")
endmodule

// ===== rtl/core/halton_jitter_settle_sequencer.sv =====
// Sub-pixel jitter sequencer (Halton base 2 / base 3) for temporal anti-aliasing.
// in_s: one request per event (prepare, frame completed, cancel) with valid/ready.
// out_m: one result per request: jitter_x/jitter_y in signed 2^-FRAC_BITS pixel
//   units (0 while disabled), more_frames and frames_left after the event.
// APB port: register 0 at byte 0 is settle_frames (reset 16), read/write, no waits.
// The flag, sequence and countdown update at the accepting edge.
// While enabled, the single bit-serial divide-by-3 unit makes ND passes over the
//   sample, then one 50-bit division per Horner digit; SMP_W = SEQ_BITS+1 (64 at
//   most), ND = floor(SMP_W*0.631)+1. While disabled the engine is not started
//   and the result is loaded from the hold state.
// One request is in flight at a time; in_s.ready rises again once the result has
//   moved into the output register, so the next request overlaps a stalled result.
// A stalled receiver holds the output register; a finished result then waits
//   inside the block and in_s.ready stays low.
// rst_n (synchronous) clears the flag, sequence, countdown and both channels.
`include "assert_macros.svh"

module halton_jitter_settle_sequencer #(
  parameter int SEQ_BITS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  hjs_in_if.sink      in_s,
  hjs_out_if.source   out_m,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hjs_pkg::*;

  localparam int SMP_W = (SEQ_BITS < 64) ? SEQ_BITS + 1 : 64;

  hjs_state_t st_r, st_nxt;

  logic                active_r, active_nxt;
  logic [SEQ_BITS-1:0] seq_r, seq_nxt;
  logic [LEFT_W-1:0]   settle_r, settle_nxt;
  logic                start_r;

  logic [LEFT_W-1:0]       settle_frames;
  hjs_eng_stat_t           eng_stat;
  logic signed [JIT_W-1:0] eng_jx, eng_jy;
  logic [SMP_W-1:0]        sample;

  logic                    in_fire, out_load;
  logic                    out_valid_r;
  logic signed [JIT_W-1:0] jx_r, jy_r;
  logic                    more_r;
  logic [LEFT_W-1:0]       left_r;

  hjs_cfg u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .settle_frames_o (settle_frames)
  );

  // event decode
  always_comb begin
    active_nxt = active_r;
    seq_nxt    = seq_r;
    settle_nxt = settle_r;
    if (in_fire) begin
      case (hjs_action_t'(in_s.action))
        ACT_PREPARE: begin
          active_nxt = in_s.enable;
          if (!in_s.enable) begin
            seq_nxt    = '0;
            settle_nxt = '0;
          end else if (!in_s.settle_ok) begin
            settle_nxt = '0;
          end else if (in_s.restart) begin
            settle_nxt = settle_frames;
          end
        end
        ACT_FRAME: begin
          if (active_r) begin
            seq_nxt = seq_r + SEQ_BITS'(1);
            if (settle_r != '0) begin
              settle_nxt = settle_r - LEFT_W'(1);
            end
          end
        end
        ACT_CANCEL: settle_nxt = '0;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_fire) st_nxt = active_nxt ? ST_RUN : ST_HOLD;
      ST_RUN:  if (eng_stat.done) st_nxt = ST_HOLD;
      ST_HOLD: if (out_load) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_s.ready = (st_r == ST_IDLE);
    in_fire    = in_s.valid && (st_r == ST_IDLE);
    out_load   = (st_r == ST_HOLD) && (!out_valid_r || out_m.ready);
  end

  assign sample = SMP_W'(seq_r) + SMP_W'(1);

  hjs_halton #(
    .SMP_W     (SMP_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_halton (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start_r),
    .sample_i (sample),
    .stat_o   (eng_stat),
    .jit_x_o  (eng_jx),
    .jit_y_o  (eng_jy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      active_r    <= 1'b0;
      seq_r       <= '0;
      settle_r    <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      active_r <= active_nxt;
      seq_r    <= seq_nxt;
      settle_r <= settle_nxt;
      start_r  <= in_fire && active_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_m.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      jx_r   <= active_r ? eng_jx : '0;
      jy_r   <= active_r ? eng_jy : '0;
      more_r <= active_r && (settle_r != '0);
      left_r <= settle_r;
    end
  end

  assign out_m.valid       = out_valid_r;
  assign out_m.jitter_x    = jx_r;
  assign out_m.jitter_y    = jy_r;
  assign out_m.more_frames = more_r;
  assign out_m.frames_left = left_r;

  `HJS_ASSERT(a_start_run, start_r |-> (st_r == ST_RUN), "engine started outside run state")
  `HJS_ASSERT(a_accept_idle, in_fire |-> !eng_stat.busy, "request accepted while engine busy")
  `HJS_ASSERT(a_zero_off, (out_load && !active_r) |=> (jx_r == '0 && jy_r == '0), "jitter not zero while disabled")
  `HJS_ASSERT(a_more, out_load |=> (more_r == (left_r != '0 && $past(active_r))), "more_frames mismatch")
endmodule
